### rtl/lmsc_pkg.sv
// ----------------------------------------------------------------------------
// lmsc_pkg
// Shared constants and types of the LED matrix scan controller.
// ----------------------------------------------------------------------------
package lmsc_pkg;

	localparam int HALF_ROWS   = 32;
	localparam int PANEL_WIDTH = 64;
	localparam int STORE_DEPTH = HALF_ROWS * PANEL_WIDTH;

	localparam int ROW_W  = $clog2(HALF_ROWS);
	localparam int COL_W  = $clog2(PANEL_WIDTH);
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int WORD_W = 6;

	localparam int POS_W   = 16;
	localparam int COLOR_W = 16;
	localparam int RSEL_W  = 5;
	localparam int COLO_W  = 6;

	localparam int RED_BIT   = 12;
	localparam int GREEN_BIT = 8;
	localparam int BLUE_BIT  = 1;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_OFF   = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic              lower;
		logic [2:0]        rgb;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_status_t;

endpackage

### rtl/led_matrix_scan_controller_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_scan_controller_unit
// Frame store and row scanner for a two-half one-bit-per-colour LED panel.
//
// channel   direction  transfer                 payload
// command   in         start && !busy           command, pos_x, pos_y, color
// result    out        strobe (one cycle)       kind, collision, row_select,
//                                               column, upper_rgb, lower_rgb, last
//
// a pixel write in the back end is a store read, then a write back;
// an off-panel write does not touch the store
// a refresh tick makes one store read per column
// after reset all HALF_ROWS * PANEL_WIDTH store words are cleared
// (2048 here), with busy high throughout
// busy rises when the two-entry command queue is full; results cannot be held
// ----------------------------------------------------------------------------
module led_matrix_scan_controller_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         command,
	input  logic [lmsc_pkg::POS_W-1:0]   pos_x,
	input  logic [lmsc_pkg::POS_W-1:0]   pos_y,
	input  logic [lmsc_pkg::COLOR_W-1:0] color,
	output logic                         strobe,
	output logic                         kind,
	output logic                         collision,
	output logic [lmsc_pkg::RSEL_W-1:0]  row_select,
	output logic [lmsc_pkg::COLO_W-1:0]  column,
	output logic [2:0]                   upper_rgb,
	output logic [2:0]                   lower_rgb,
	output logic                         last
);
	import lmsc_pkg::*;

	head_t        head;
	back_status_t status;

	lmsc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.color  (color),
		.busy   (busy),
		.status (status),
		.head   (head)
	);

	lmsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.strobe    (strobe),
		.kind      (kind),
		.collision (collision),
		.row_select(row_select),
		.column    (column),
		.upper_rgb (upper_rgb),
		.lower_rgb (lower_rgb),
		.last      (last)
	);

endmodule

### rtl/lmsc_ram.sv
// ----------------------------------------------------------------------------
// lmsc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lmsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/lmsc_front.sv
// ----------------------------------------------------------------------------
// lmsc_front
// Command intake: position check, row remap, colour pick and a short queue.
// ----------------------------------------------------------------------------
module lmsc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         command,
	input  logic [lmsc_pkg::POS_W-1:0]   pos_x,
	input  logic [lmsc_pkg::POS_W-1:0]   pos_y,
	input  logic [lmsc_pkg::COLOR_W-1:0] color,
	output logic                         busy,
	input  lmsc_pkg::back_status_t       status,
	output lmsc_pkg::head_t              head
);
	import lmsc_pkg::*;

	localparam logic [POS_W-1:0]  PW_P  = POS_W'(PANEL_WIDTH);
	localparam logic [POS_W-1:0]  HR_P  = POS_W'(HALF_ROWS);
	localparam logic [POS_W-1:0]  ROWS_P = POS_W'(2 * HALF_ROWS);
	localparam logic [ADDR_W-1:0] PW_A  = ADDR_W'(PANEL_WIDTH);

	entry_t            q_mem [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic [POS_W-1:0]  mapped;
	logic [POS_W-1:0]  row_full;
	logic              lower;
	logic [ADDR_W-1:0] addr;
	entry_t            new_entry;
	logic              push;

	always_comb begin
		if (pos_y == '0) begin
			mapped = HR_P - POS_W'(1);
		end else if (pos_y == HR_P) begin
			mapped = ROWS_P - POS_W'(1);
		end else begin
			mapped = pos_y - POS_W'(1);
		end
		lower    = (mapped >= HR_P);
		row_full = lower ? (mapped - HR_P) : mapped;
		addr     = ADDR_W'(row_full[ROW_W-1:0]) * PW_A + ADDR_W'(pos_x[COL_W-1:0]);

		new_entry.addr  = addr;
		new_entry.lower = lower;
		new_entry.rgb   = {color[BLUE_BIT], color[GREEN_BIT], color[RED_BIT]};
		if (command) begin
			new_entry.op = OP_TICK;
		end else if (pos_x >= PW_P || pos_y >= ROWS_P) begin
			new_entry.op = OP_OFF;
		end else begin
			new_entry.op = OP_WRITE;
		end
	end

	assign busy       = status.clearing || (count_q == QCNT_W'(Q_DEPTH));
	assign push       = start && !busy;
	assign head.valid = (count_q != '0);
	assign head.entry = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (status.pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, status.pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/lmsc_back.sv
// ----------------------------------------------------------------------------
// lmsc_back
// Frame store owner: clearing sweep, pixel read-modify-write and row scan.
// ----------------------------------------------------------------------------
module lmsc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lmsc_pkg::head_t             head,
	output lmsc_pkg::back_status_t      status,
	output logic                        strobe,
	output logic                        kind,
	output logic                        collision,
	output logic [lmsc_pkg::RSEL_W-1:0] row_select,
	output logic [lmsc_pkg::COLO_W-1:0] column,
	output logic [2:0]                  upper_rgb,
	output logic [2:0]                  lower_rgb,
	output logic                        last
);
	import lmsc_pkg::*;

	localparam logic [ADDR_W-1:0] PW_A = ADDR_W'(PANEL_WIDTH);

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_WB,
		B_SCAN
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [ROW_W-1:0]  scan_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] addr_q;
	logic              lower_q;
	logic [2:0]        rgb_q;
	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic              last_s1;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;
	logic [ADDR_W-1:0] raddr;
	logic [WORD_W-1:0] rdata;
	logic              pop;
	logic [ROW_W-1:0]  scan_nxt;

	lmsc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign pop             = (state_q == B_IDLE) && head.valid && !valid_s1;
	assign status.pop      = pop;
	assign status.clearing = (state_q == B_CLEAR);
	assign scan_nxt        = (scan_q == ROW_W'(HALF_ROWS - 1)) ? '0 : scan_q + ROW_W'(1);

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = lower_q ? {rgb_q, rdata[2:0]} : {rdata[5:3], rgb_q};
		raddr = head.entry.addr;
		unique case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			B_WB: begin
				we = 1'b1;
			end
			B_SCAN: begin
				raddr = ADDR_W'(scan_q) * PW_A + ADDR_W'(col_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLEAR;
			clr_q    <= '0;
			scan_q   <= ROW_W'(HALF_ROWS - 1);
			col_q    <= '0;
			valid_s1 <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			strobe   <= 1'b0;
			valid_s1 <= 1'b0;
			if (valid_s1) begin
				strobe     <= 1'b1;
				kind       <= 1'b1;
				collision  <= 1'b0;
				row_select <= RSEL_W'(scan_q);
				column     <= COLO_W'(col_s1);
				upper_rgb  <= rdata[2:0];
				lower_rgb  <= rdata[5:3];
				last       <= last_s1;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						addr_q  <= head.entry.addr;
						lower_q <= head.entry.lower;
						rgb_q   <= head.entry.rgb;
						unique case (head.entry.op)
							OP_WRITE: state_q <= B_WB;
							OP_OFF: begin
								strobe     <= 1'b1;
								kind       <= 1'b0;
								collision  <= 1'b1;
								row_select <= '0;
								column     <= '0;
								upper_rgb  <= '0;
								lower_rgb  <= '0;
								last       <= 1'b1;
							end
							OP_TICK: begin
								scan_q  <= scan_nxt;
								col_q   <= '0;
								state_q <= B_SCAN;
							end
							default: state_q <= B_IDLE;
						endcase
					end
				end
				B_WB: begin
					strobe     <= 1'b1;
					kind       <= 1'b0;
					collision  <= lower_q ? (rdata[5:3] != '0) : (rdata[2:0] != '0);
					row_select <= '0;
					column     <= '0;
					upper_rgb  <= '0;
					lower_rgb  <= '0;
					last       <= 1'b1;
					state_q    <= B_IDLE;
				end
				B_SCAN: begin
					valid_s1 <= 1'b1;
					col_s1   <= col_q;
					last_s1  <= (col_q == COL_W'(PANEL_WIDTH - 1));
					col_q    <= col_q + COL_W'(1);
					if (col_q == COL_W'(PANEL_WIDTH - 1)) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
